// ===== src/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// shared types, constants and helpers of the power-by-squaring unit
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int EXP_WIDTH_DEF = 32;

    localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEF_NAN_BITS = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

    typedef enum logic {
        FOP_MUL,
        FOP_DIV
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_DIV,
        F_ALIGN,
        F_DENORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SCAN,
        T_WAIT_ACC,
        T_WAIT_SQ,
        T_WAIT_DIV,
        T_DONE
    } top_state_t;

    function automatic logic is_nan(input logic [63:0] x);
        is_nan = (x[62:52] == EXP_ALL_ONES) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        is_inf = (x[62:52] == EXP_ALL_ONES) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        is_zero = (x[62:0] == 63'd0);
    endfunction

    // significand with hidden bit
    function automatic logic [52:0] mant_of(input logic [63:0] x);
        mant_of = {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    // unbiased exponent, subnormals at -1022
    function automatic logic signed [13:0] exp_of(input logic [63:0] x);
        if (x[62:52] == 11'd0) begin
            exp_of = -14'sd1022;
        end else begin
            exp_of = $signed({3'b000, x[62:52]}) - 14'sd1023;
        end
    endfunction

endpackage

// ===== src/power_by_squaring_unit.sv =====
// ----------------------------------------------------------------------------
// power_by_squaring_unit
// double-precision base raised to a signed integer power by square-and-multiply
// ----------------------------------------------------------------------------
// work per item: one square per bit below the top set bit plus one multiply per
//   set bit, a reciprocal for a negative power, no fpu operation for zero; a zero,
//   inf or nan operand takes a short fpu path, a subnormal extra normalize steps
// throughput: one item at a time, set by the single shared multiply/divide unit
// reset: synchronous active-low aresetn returns the sequencer to idle, no
//   result pending
module power_by_squaring_unit #(
    parameter int EXP_WIDTH = pbs_pkg::EXP_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_base_bits,
    input  logic [EXP_WIDTH-1:0] s_exponent,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_result_bits
);

    pbs_pkg::top_state_t  state_reg, state_next;
    logic [EXP_WIDTH-1:0] mag_reg, mag_next;   // exponent magnitude, scanned lsb first
    logic                 neg_reg, neg_next;
    logic [63:0]          acc_reg, acc_next;   // running product
    logic [63:0]          sq_reg, sq_next;     // running square of the base
    logic [63:0]          res_reg, res_next;   // output holding register

    pbs_pkg::fpu_req_t    fpu_req;
    logic [63:0]          fpu_a, fpu_b, fpu_y;
    logic                 fpu_done;

    pbs_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .a       (fpu_a),
        .b       (fpu_b),
        .done    (fpu_done),
        .y       (fpu_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbs_pkg::T_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        res_next   = res_reg;
        fpu_req    = '{start: 1'b0, op: pbs_pkg::FOP_MUL};
        fpu_a      = acc_reg;
        fpu_b      = sq_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        case (state_reg)
            pbs_pkg::T_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // magnitude of the most negative exponent wraps to 2^(w-1)
                    neg_next = s_exponent[EXP_WIDTH-1];
                    mag_next = s_exponent[EXP_WIDTH-1] ? (~s_exponent + 1'b1) : s_exponent;
                    acc_next = pbs_pkg::ONE_BITS;
                    sq_next  = s_base_bits;
                    state_next = pbs_pkg::T_SCAN;
                end
            end

            pbs_pkg::T_SCAN: begin
                if (mag_reg == '0) begin
                    if (neg_reg) begin
                        // reciprocal, a zero accumulator gives a signed infinity
                        fpu_req    = '{start: 1'b1, op: pbs_pkg::FOP_DIV};
                        fpu_a      = pbs_pkg::ONE_BITS;
                        fpu_b      = acc_reg;
                        state_next = pbs_pkg::T_WAIT_DIV;
                    end else begin
                        res_next   = acc_reg;
                        state_next = pbs_pkg::T_DONE;
                    end
                end else if (mag_reg[0]) begin
                    fpu_req    = '{start: 1'b1, op: pbs_pkg::FOP_MUL};
                    state_next = pbs_pkg::T_WAIT_ACC;
                end else begin
                    // square only when a higher bit still needs it
                    fpu_req    = '{start: 1'b1, op: pbs_pkg::FOP_MUL};
                    fpu_a      = sq_reg;
                    state_next = pbs_pkg::T_WAIT_SQ;
                end
            end

            pbs_pkg::T_WAIT_ACC: begin
                if (fpu_done) begin
                    acc_next    = fpu_y;
                    mag_next[0] = 1'b0;
                    state_next  = pbs_pkg::T_SCAN;
                end
            end

            pbs_pkg::T_WAIT_SQ: begin
                if (fpu_done) begin
                    sq_next    = fpu_y;
                    mag_next   = mag_reg >> 1;
                    state_next = pbs_pkg::T_SCAN;
                end
            end

            pbs_pkg::T_WAIT_DIV: begin
                if (fpu_done) begin
                    res_next   = fpu_y;
                    state_next = pbs_pkg::T_DONE;
                end
            end

            // result held until the downstream transfer
            pbs_pkg::T_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = pbs_pkg::T_IDLE;
                end
            end

            default: begin
                state_next = pbs_pkg::T_IDLE;
            end
        endcase
    end

    assign m_result_bits = res_reg;

endmodule

// ===== src/pbs_fpu.sv =====
// ----------------------------------------------------------------------------
// pbs_fpu
// multi-cycle double-precision multiply / divide, round to nearest even
// ----------------------------------------------------------------------------
module pbs_fpu (
    input  logic               aclk,
    input  logic               aresetn,
    input  pbs_pkg::fpu_req_t  req,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic [63:0]        y
);

    pbs_pkg::fpu_state_t state_reg, state_next;
    pbs_pkg::fpu_op_t    op_reg, op_next;
    logic                sign_reg, sign_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic signed [13:0]  ea_reg, ea_next, eb_reg, eb_next;
    logic signed [13:0]  be_reg, be_next;
    logic [105:0]        m_reg, m_next;
    logic [105:0]        prod_reg, prod_next;
    logic [53:0]         pp_reg, pp_next;
    logic [1:0]          sh_reg, sh_next;
    logic [53:0]         rem_reg, rem_next;
    logic [54:0]         q_reg, q_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         y_reg, y_next;

    logic [26:0]  px, py;
    logic [105:0] pp_shifted;
    logic [53:0]  rem_diff;
    logic [52:0]  mant53;
    logic         round_up;
    logic [53:0]  r54;
    logic signed [13:0] fe;
    logic [52:0]  fmant;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbs_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        sign_reg <= sign_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        be_reg   <= be_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        pp_reg   <= pp_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        y_reg    <= y_next;
    end

    // partial product operand select, 27-bit halves
    always_comb begin
        px = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        py = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        case (sh_reg)
            2'd0:    pp_shifted = {52'd0, pp_reg};
            2'd1:    pp_shifted = {25'd0, pp_reg, 27'd0};
            2'd2:    pp_shifted = {pp_reg[51:0], 54'd0};
            default: pp_shifted = 106'd0;
        endcase
        rem_diff = rem_reg - {1'b0, mb_reg};
        // rounding
        mant53   = m_reg[105:53];
        round_up = m_reg[52] & ((|m_reg[51:0]) | mant53[0]);
        r54      = {1'b0, mant53} + {53'd0, round_up};
        if (r54[53]) begin
            fe    = be_reg + 14'sd1;
            fmant = r54[53:1];
        end else begin
            fe    = r54[52] ? be_reg : 14'sd0;
            fmant = r54[52:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sign_next  = sign_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        be_next    = be_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        y_next     = y_reg;
        done       = 1'b0;

        case (state_reg)
            pbs_pkg::F_IDLE: begin
                if (req.start) begin
                    op_next   = req.op;
                    sign_next = a[63] ^ b[63];
                    ma_next   = pbs_pkg::mant_of(a);
                    mb_next   = pbs_pkg::mant_of(b);
                    ea_next   = pbs_pkg::exp_of(a);
                    eb_next   = pbs_pkg::exp_of(b);
                    state_next = pbs_pkg::F_DONE;
                    if (pbs_pkg::is_nan(a)) begin
                        y_next = a | pbs_pkg::QUIET_BIT;
                    end else if (pbs_pkg::is_nan(b)) begin
                        y_next = b | pbs_pkg::QUIET_BIT;
                    end else if (req.op == pbs_pkg::FOP_MUL) begin
                        if ((pbs_pkg::is_inf(a) && pbs_pkg::is_zero(b)) ||
                            (pbs_pkg::is_zero(a) && pbs_pkg::is_inf(b))) begin
                            y_next = pbs_pkg::DEF_NAN_BITS;
                        end else if (pbs_pkg::is_inf(a) || pbs_pkg::is_inf(b)) begin
                            y_next = {a[63] ^ b[63], pbs_pkg::EXP_ALL_ONES, 52'd0};
                        end else if (pbs_pkg::is_zero(a) || pbs_pkg::is_zero(b)) begin
                            y_next = {a[63] ^ b[63], 63'd0};
                        end else begin
                            state_next = pbs_pkg::F_NORM;
                        end
                    end else begin
                        if ((pbs_pkg::is_inf(a) && pbs_pkg::is_inf(b)) ||
                            (pbs_pkg::is_zero(a) && pbs_pkg::is_zero(b))) begin
                            y_next = pbs_pkg::DEF_NAN_BITS;
                        end else if (pbs_pkg::is_inf(a) || pbs_pkg::is_zero(b)) begin
                            y_next = {a[63] ^ b[63], pbs_pkg::EXP_ALL_ONES, 52'd0};
                        end else if (pbs_pkg::is_inf(b) || pbs_pkg::is_zero(a)) begin
                            y_next = {a[63] ^ b[63], 63'd0};
                        end else begin
                            state_next = pbs_pkg::F_NORM;
                        end
                    end
                end
            end

            // subnormal operands: one bit per cycle until hidden bit set
            pbs_pkg::F_NORM: begin
                if (ma_reg[52] && mb_reg[52]) begin
                    cnt_next = 6'd0;
                    if (op_reg == pbs_pkg::FOP_MUL) begin
                        prod_next  = 106'd0;
                        state_next = pbs_pkg::F_MUL;
                    end else begin
                        q_next = 55'd0;
                        if (ma_reg < mb_reg) begin
                            rem_next = {ma_reg, 1'b0};
                            ea_next  = ea_reg - 14'sd1;
                        end else begin
                            rem_next = {1'b0, ma_reg};
                        end
                        state_next = pbs_pkg::F_DIV;
                    end
                end else begin
                    if (!ma_reg[52]) begin
                        ma_next = {ma_reg[51:0], 1'b0};
                        ea_next = ea_reg - 14'sd1;
                    end
                    if (!mb_reg[52]) begin
                        mb_next = {mb_reg[51:0], 1'b0};
                        eb_next = eb_reg - 14'sd1;
                    end
                end
            end

            // four 27x27 partial products, each registered and added in the next cycle
            pbs_pkg::F_MUL: begin
                if (cnt_reg != 6'd4) begin
                    pp_next = px * py;
                    sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != 6'd0) begin
                    prod_next = prod_reg + pp_shifted;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4) begin
                    state_next = pbs_pkg::F_ALIGN;
                end
            end

            // restoring division, one quotient bit per cycle
            pbs_pkg::F_DIV: begin
                if (rem_reg >= {1'b0, mb_reg}) begin
                    rem_next = {rem_diff[52:0], 1'b0};
                    q_next   = {q_reg[53:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[52:0], 1'b0};
                    q_next   = {q_reg[53:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd54) begin
                    state_next = pbs_pkg::F_ALIGN;
                end
            end

            pbs_pkg::F_ALIGN: begin
                if (op_reg == pbs_pkg::FOP_MUL) begin
                    if (prod_reg[105]) begin
                        m_next  = prod_reg;
                        be_next = ea_reg + eb_reg + 14'sd1024;
                    end else begin
                        m_next  = {prod_reg[104:0], 1'b0};
                        be_next = ea_reg + eb_reg + 14'sd1023;
                    end
                end else begin
                    m_next  = {q_reg, 50'd0, (rem_reg != 54'd0)};
                    be_next = ea_reg - eb_reg + 14'sd1023;
                end
                state_next = pbs_pkg::F_DENORM;
            end

            // gradual underflow: shift right with sticky until exponent is 1, or collapse to sticky when far below
            pbs_pkg::F_DENORM: begin
                if (be_reg >= 14'sd1) begin
                    state_next = pbs_pkg::F_ROUND;
                end else if (be_reg < -14'sd110) begin
                    m_next  = {105'd0, |m_reg};
                    be_next = 14'sd1;
                end else begin
                    m_next  = {1'b0, m_reg[105:2], m_reg[1] | m_reg[0]};
                    be_next = be_reg + 14'sd1;
                end
            end

            pbs_pkg::F_ROUND: begin
                if (fe >= 14'sd2047) begin
                    y_next = {sign_reg, pbs_pkg::EXP_ALL_ONES, 52'd0};
                end else begin
                    y_next = {sign_reg, fe[10:0], fmant[51:0]};
                end
                state_next = pbs_pkg::F_DONE;
            end

            pbs_pkg::F_DONE: begin
                done       = 1'b1;
                state_next = pbs_pkg::F_IDLE;
            end

            default: begin
                state_next = pbs_pkg::F_IDLE;
            end
        endcase
    end

    assign y = y_reg;

endmodule

// ===== src/pbs_checker.sv =====
// ----------------------------------------------------------------------------
// pbs_checker
// port-level checks of the power-by-squaring unit
// ----------------------------------------------------------------------------
module pbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result_bits
);

    // one item in flight: never ready while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    // an accepted item never yields a result on the next cycle
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid && !s_ready)
        else $error("result or ready right after input transfer");

    // after an output transfer the unit is free again
    a_free_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready && !m_valid)
        else $error("not ready after output transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_result_bits))
        else $error("stalled result changed");

endmodule

bind power_by_squaring_unit pbs_checker u_pbs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_bits (m_result_bits)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// power_by_squaring_unit testbench
// drives double bases and signed integer powers through the valid/ready
// input channel, predicts each result with simulator double arithmetic and
// compares every transfer on the result channel in order
// ----------------------------------------------------------------------------

// expected results of accepted transfers, oldest first
class power_scoreboard;
    logic [63:0] pending_powers[$];

    // square-and-multiply on the base, reciprocal for a negative power
    function automatic logic [63:0] predict_power(logic [63:0] base, logic [31:0] power);
        logic        negative;
        logic [32:0] magnitude;
        real         square;
        real         accum;
        logic [63:0] accum_bits;
        negative  = power[31];
        // the most negative power keeps its 2^31 magnitude in 33 bits
        magnitude = negative ? (33'd0 - {1'b1, power}) : {1'b0, power};
        square    = $bitstoreal(base);
        accum     = 1.0;
        while (magnitude != 33'd0) begin
            if (magnitude[0]) begin
                accum = accum * square;
            end
            magnitude = magnitude >> 1;
            square    = square * square;
        end
        accum_bits = $realtobits(accum);
        if (!negative) begin
            return accum_bits;
        end
        // reciprocal of a zero keeps the sign of the zero
        if (accum_bits[62:0] == 63'd0) begin
            return {accum_bits[63], 63'h7FF0_0000_0000_0000};
        end
        return $realtobits(1.0 / accum);
    endfunction

    function void note_input(logic [63:0] base, logic [31:0] power);
        pending_powers.push_back(predict_power(base, power));
    endfunction

    // empty string when the result matches
    function string check_result(logic [63:0] got);
        logic [63:0] want;
        if (pending_powers.size() == 0) begin
            return $sformatf("result %h with nothing expected", got);
        end
        want = pending_powers.pop_front();
        if (got !== want) begin
            return $sformatf("result_bits %h, expected %h", got, want);
        end
        return "";
    endfunction

    function int outstanding();
        return pending_powers.size();
    endfunction
endclass

module testbench;

    localparam int  NUM_RANDOM  = 950;
    localparam int  CYCLE_LIMIT = 4000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_base_bits;
    logic [31:0] s_exponent;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_bits;

    power_scoreboard power_sb;
    int              mismatches = 0;
    int              cycles = 0;
    // idle chance in percent for each side, changed between phases
    int              tx_idle_pct;
    int              rx_idle_pct;
    string           msg;

    power_by_squaring_unit #(.EXP_WIDTH(32)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_bits   (s_base_bits),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_bits (m_result_bits)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string text);
        $display("mismatch at cycle %0d: %s", cycles, text);
        mismatches++;
    endtask

    // one input transfer; random idle cycles ahead of it, then hold until taken
    task automatic send_power(input logic [63:0] base, input logic [31:0] power);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_base_bits <= base;
        s_exponent  <= power;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // random base; at times a biased exponent near one so long powers stay in range
    function automatic logic [63:0] pick_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(5))
            0, 1: begin
            end
            2, 3: begin
                // near 1.0 in magnitude
                b[62:52] = 11'h3FF + 11'($urandom_range(8)) - 11'd4;
            end
            4: begin
                // subnormal or tiny
                b[62:52] = 11'($urandom_range(2));
            end
            default: begin
                // inf or nan
                b[62:52] = 11'h7FF;
                if ($urandom_range(1) == 0) begin
                    b[51:0] = 52'd0;
                end
            end
        endcase
        return b;
    endfunction

    function automatic logic [31:0] pick_power();
        case ($urandom_range(3))
            0, 1:    return 32'($signed($urandom_range(80)) - 40);
            2:       return 32'($signed($urandom_range(4000)) - 2000);
            default: return $urandom;
        endcase
    endfunction

    // monitors and receiver: sample pre-edge values, drive with nonblocking
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) begin
            power_sb.note_input(s_base_bits, s_exponent);
        end
        if (aresetn && m_valid && m_ready) begin
            msg = power_sb.check_result(m_result_bits);
            if (msg != "") begin
                report_mismatch(msg);
            end
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] dir_bases[12];
        logic [31:0] dir_powers[8];
        int          n;

        power_sb    = new();
        tx_idle_pct = 33;
        rx_idle_pct = 61;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_base_bits = 64'd0;
        s_exponent  = 32'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zeros, infinities, quiet and signaling nan, unit values,
        // smallest subnormal, largest finite, against edge powers
        dir_bases = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                      64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0001,
                      64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
                      64'hC000_0000_0000_0000, 64'h0000_0000_0000_0001,
                      64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        dir_powers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'd2, 32'hFFFF_FFFD, 32'd3};
        for (int i = 0; i < 12; i++) begin
            send_power(dir_bases[i], dir_powers[i % 8]);
        end
        send_power(64'h0000_0000_0000_0000, 32'h8000_0000);
        send_power(64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
        send_power(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF);
        send_power(64'hBFEF_FFFF_FFFF_FFFF, 32'h8000_0000);
        send_power(64'h4000_0000_0000_0000, 32'd1023);
        send_power(64'h4000_0000_0000_0000, 32'hFFFF_FBCE);
        send_power(64'h0010_0000_0000_0000, 32'hFFFF_FFFF);
        send_power(64'h7FF8_0000_0000_0000, 32'd0);

        // random part in three idling phases
        n = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 61;
                rx_idle_pct = 33;
            end else if (phase == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int i = 0; i < NUM_RANDOM / 3; i++) begin
                send_power(pick_base(), pick_power());
                n++;
            end
        end
        s_valid <= 1'b0;

        while (power_sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        // allow for a stray extra result
        repeat (200) @(posedge aclk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/pbs_pkg.sv
src/pbs_fpu.sv
src/power_by_squaring_unit.sv
src/pbs_checker.sv
test/testbench.sv
